FILE: src/wom_pkg.sv
// Shared types and constants of the wire outline miter block.
package wom_pkg;

   localparam int CoordW = 32;
   localparam int PointW = 42;
   localparam int CornerW = 40;
   localparam int StepW = 33;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_WIDTH = 3'd1;
   localparam logic [2:0] ERR_ZERO = 3'd2;
   localparam logic [2:0] ERR_SHARP = 3'd3;
   localparam logic [2:0] ERR_PARALLEL = 3'd4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_SEGMENT = 1'b1;

   // One item as it travels from the front part to the back part.
   typedef struct packed {
      logic op;
      logic signed [CoordW-1:0] coord_x;
      logic signed [CoordW-1:0] coord_y;
      logic signed [CoordW-1:0] wire_width;
      logic final_segment;
   } item_type;

   localparam int ItemW = $bits(item_type);

endpackage

FILE: src/wom_queue.sv
// Two-entry queue that parts the front part from the back part.
module wom_queue
   import wom_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  item_type in_item,
   output logic out_valid,
   input  logic out_ready,
   output item_type out_item
);

   item_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

FILE: src/wom_engine.sv
// Back part: error checks, unit directions, offsets and miter corners.
module wom_engine
   import wom_pkg::*;
#(
   parameter int MAX_VERTICES = 1024
)
(
   input  logic clock,
   input  logic reset,
   input  logic item_valid,
   output logic item_ready,
   input  item_type item,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [PointW-1:0] rsp_right_x,
   output logic signed [PointW-1:0] rsp_right_y,
   output logic signed [PointW-1:0] rsp_left_x,
   output logic signed [PointW-1:0] rsp_left_y,
   output logic [10:0] rsp_vertex_number,
   output logic [2:0] rsp_error_code,
   output logic rsp_last_pair
);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_CHK    = 12'b000000000010,
      S_NORM   = 12'b000000000100,
      S_SQRT   = 12'b000000001000,
      S_DIVX   = 12'b000000010000,
      S_DIVY   = 12'b000000100000,
      S_OFFS   = 12'b000001000000,
      S_DEN    = 12'b000010000000,
      S_VDIVX  = 12'b000100000000,
      S_VDIVY  = 12'b001000000000,
      S_EMIT   = 12'b010000000000,
      S_EMIT2  = 12'b100000000000
   } state_type;

   state_type state_ff;

   // wire state
   logic signed [31:0] hw_ff;
   logic signed [CornerW-1:0] cx_ff, cy_ff;
   logic signed [StepW-1:0] psx_ff, psy_ff;
   logic signed [PointW-1:0] pox_ff, poy_ff;
   logic [10:0] seg_ff;

   item_type it_ff;
   // direction work
   logic pass_ff;            // 0: this step, 1: prior step
   logic [63:0] ax_ff, ay_ff;
   logic [63:0] sq_s_ff, sq_res_ff, sq_bit_ff;
   logic [63:0] len_ff;
   logic [72:0] num_ff;      // dividend / remainder register
   logic [63:0] quo_ff;
   logic [6:0] cnt_ff;
   logic signed [9:0] ux2_ff, uy2_ff, ux1_ff, uy1_ff;
   logic signed [PointW-1:0] ox2_ff, oy2_ff;
   logic neg_ff;
   logic signed [PointW+1:0] vx_ff, vy_ff;
   // multiply products, registered
   logic signed [65:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic [2:0] chk_ff;

   // output register
   logic ov_ff;
   logic signed [PointW-1:0] orx_ff, ory_ff, olx_ff, oly_ff;
   logic [10:0] ovn_ff;
   logic [2:0] oerr_ff;
   logic olast_ff;

   logic out_free;
   assign out_free = !ov_ff || rsp_ready;
   assign item_ready = (state_ff == S_IDLE);

   assign rsp_valid = ov_ff;
   assign rsp_right_x = orx_ff;
   assign rsp_right_y = ory_ff;
   assign rsp_left_x = olx_ff;
   assign rsp_left_y = oly_ff;
   assign rsp_vertex_number = ovn_ff;
   assign rsp_error_code = oerr_ff;
   assign rsp_last_pair = olast_ff;

   localparam logic [10:0] LastK = 11'(MAX_VERTICES - 1);

   // signed step values
   logic signed [StepW-1:0] sx, sy;
   assign sx = StepW'(it_ff.coord_x);
   assign sy = StepW'(it_ff.coord_y);

   logic [63:0] cur_ax, cur_ay, mx;
   assign mx = (ax_ff > ay_ff) ? ax_ff : ay_ff;

   logic [63:0] sq_sum;
   logic signed [PointW+24:0] vnum;
   logic signed [PointW-1:0] hw_wide;
   logic signed [PointW+9:0] prod_x, prod_y;
   logic final_pair;
   logic signed [CornerW-1:0] ncx, ncy;

   always_comb begin
      // normalized magnitudes stay within 32 bits
      sq_sum = {32'd0, ax_ff[31:0]} * {32'd0, ax_ff[31:0]}
             + {32'd0, ay_ff[31:0]} * {32'd0, ay_ff[31:0]};
      hw_wide = PointW'(hw_ff);
      prod_x = (PointW+10)'(hw_wide) * (PointW+10)'(uy2_ff);
      prod_y = (PointW+10)'(hw_wide) * (PointW+10)'(ux2_ff);
      vnum = ((PointW+25)'(pox_ff) + (PointW+25)'(ox2_ff)) <<< 16;
      final_pair = it_ff.final_segment || (seg_ff >= LastK);
      ncx = cx_ff + CornerW'({sx, 8'd0});
      ncy = cy_ff + CornerW'({sy, 8'd0});
      cur_ax = 64'(pass_ff ? (psx_ff < 0 ? -psx_ff : psx_ff) : (sx < 0 ? -sx : sx));
      cur_ay = 64'(pass_ff ? (psy_ff < 0 ? -psy_ff : psy_ff) : (sy < 0 ? -sy : sy));
   end

   task automatic put_err(input logic [2:0] code);
      orx_ff <= '0; ory_ff <= '0; olx_ff <= '0; oly_ff <= '0;
      ovn_ff <= seg_ff;
      oerr_ff <= code;
      olast_ff <= 1'b0;
   endtask

   always_ff @(posedge clock) begin
      logic emit_now;
      emit_now = 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
         hw_ff <= '0;
         cx_ff <= '0; cy_ff <= '0;
         psx_ff <= '0; psy_ff <= '0;
         pox_ff <= '0; poy_ff <= '0;
         seg_ff <= '0;
         pass_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  it_ff <= item;
                  state_ff <= S_CHK;
                  chk_ff <= 3'd0;
               end
            end
            S_CHK: begin
               // products of the turn and parallel tests, then decide
               if (chk_ff == 3'd0) begin
                  pa_ff <= 66'(psx_ff) * 66'(sx);
                  pb_ff <= 66'(psy_ff) * 66'(sy);
                  pc_ff <= 66'(sx) * 66'(psy_ff);
                  pd_ff <= 66'(psx_ff) * 66'(sy);
                  chk_ff <= 3'd1;
               end else if (out_free) begin
                  if (it_ff.op == OP_START) begin
                     cx_ff <= CornerW'({it_ff.coord_x, 8'd0});
                     cy_ff <= CornerW'({it_ff.coord_y, 8'd0});
                     seg_ff <= '0;
                     psx_ff <= '0; psy_ff <= '0;
                     pox_ff <= '0; poy_ff <= '0;
                     state_ff <= S_IDLE;
                     if (it_ff.wire_width <= 0) begin
                        hw_ff <= '0;
                        emit_now = 1'b1;
                        orx_ff <= '0; ory_ff <= '0; olx_ff <= '0; oly_ff <= '0;
                        ovn_ff <= '0; oerr_ff <= ERR_WIDTH; olast_ff <= 1'b0;
                     end else begin
                        hw_ff <= it_ff.wire_width;
                     end
                  end else if (hw_ff == 0) begin
                     put_err(ERR_WIDTH); emit_now = 1'b1; state_ff <= S_IDLE;
                  end else if (sx == 0 && sy == 0) begin
                     put_err(ERR_ZERO); emit_now = 1'b1; state_ff <= S_IDLE;
                  end else if (seg_ff != 0 && pa_ff < -pb_ff) begin
                     put_err(ERR_SHARP); emit_now = 1'b1; state_ff <= S_IDLE;
                  end else if (seg_ff != 0 && pc_ff == pd_ff) begin
                     put_err(ERR_PARALLEL); emit_now = 1'b1; state_ff <= S_IDLE;
                  end else begin
                     pass_ff <= 1'b0;
                     state_ff <= S_NORM;
                     chk_ff <= 3'd0;
                  end
               end
            end
            S_NORM: begin
               // load magnitudes, then shift one bit a cycle up to 2^30
               if (chk_ff == 3'd0) begin
                  ax_ff <= cur_ax; ay_ff <= cur_ay;
                  neg_ff <= 1'b0;
                  chk_ff <= 3'd1;
               end else if (mx < 64'(1) << 30) begin
                  ax_ff <= ax_ff << 1; ay_ff <= ay_ff << 1;
               end else begin
                  sq_s_ff <= sq_sum;
                  sq_res_ff <= '0;
                  sq_bit_ff <= 64'(1) << 62;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (sq_bit_ff == 0) begin
                  len_ff <= sq_res_ff;
                  num_ff <= 73'(ax_ff * 256 + (sq_res_ff >> 1));
                  quo_ff <= '0; cnt_ff <= 7'd0;
                  state_ff <= S_DIVX;
               end else if (sq_bit_ff > sq_s_ff && sq_res_ff == 0) begin
                  sq_bit_ff <= sq_bit_ff >> 2;
               end else begin
                  if (sq_s_ff >= sq_res_ff + sq_bit_ff) begin
                     sq_s_ff <= sq_s_ff - (sq_res_ff + sq_bit_ff);
                     sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
                  end else begin
                     sq_res_ff <= sq_res_ff >> 1;
                  end
                  sq_bit_ff <= sq_bit_ff >> 2;
               end
            end
            S_DIVX, S_DIVY, S_VDIVX, S_VDIVY: begin
               // restoring division, one quotient bit a cycle
               if (cnt_ff == 7'd0) begin
                  quo_ff <= '0;
                  cnt_ff <= 7'd1;
                  sq_s_ff <= num_ff[63:0];  // dividend
                  num_ff <= '0;             // partial remainder
               end else if (cnt_ff <= 7'd64) begin
                  logic [72:0] r;
                  r = {num_ff[71:0], sq_s_ff[63]};
                  sq_s_ff <= sq_s_ff << 1;
                  if (r >= 73'(len_ff)) begin
                     num_ff <= r - 73'(len_ff);
                     quo_ff <= {quo_ff[62:0], 1'b1};
                  end else begin
                     num_ff <= r;
                     quo_ff <= {quo_ff[62:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 7'd1;
               end else begin
                  cnt_ff <= 7'd0;
                  if (state_ff == S_DIVX) begin
                     if (pass_ff) ux1_ff <= 10'(psx_ff < 0 ? -quo_ff : quo_ff);
                     else ux2_ff <= 10'(sx < 0 ? -quo_ff : quo_ff);
                     num_ff <= 73'(ay_ff * 256 + (len_ff >> 1));
                     state_ff <= S_DIVY;
                  end else if (state_ff == S_DIVY) begin
                     if (pass_ff) begin
                        uy1_ff <= 10'(psy_ff < 0 ? -quo_ff : quo_ff);
                        state_ff <= S_DEN;
                     end else begin
                        uy2_ff <= 10'(sy < 0 ? -quo_ff : quo_ff);
                        state_ff <= S_OFFS;
                     end
                  end else if (state_ff == S_VDIVX) begin
                     vx_ff <= (PointW+2)'(neg_ff ? -quo_ff : quo_ff);
                     begin
                        logic signed [PointW+24:0] vn2;
                        vn2 = ((PointW+25)'(poy_ff) + (PointW+25)'(oy2_ff)) <<< 16;
                        neg_ff <= vn2 < 0;
                        num_ff <= 73'(vn2 < 0 ? -vn2 : vn2);
                     end
                     state_ff <= S_VDIVY;
                  end else begin
                     vy_ff <= (PointW+2)'(neg_ff ? -quo_ff : quo_ff);
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_OFFS: begin
               ox2_ff <= PointW'(prod_x / 2);
               oy2_ff <= PointW'(-(prod_y / 2));
               if (seg_ff == 0) begin
                  state_ff <= S_EMIT;
               end else begin
                  pass_ff <= 1'b1;
                  chk_ff <= 3'd0;
                  state_ff <= S_NORM;
               end
            end
            S_DEN: begin
               begin
                  logic signed [31:0] d;
                  d = 32'sd65536 + 32'(ux1_ff) * 32'(ux2_ff) + 32'(uy1_ff) * 32'(uy2_ff);
                  len_ff <= 64'((d < 1) ? 32'sd1 : d);
               end
               neg_ff <= vnum < 0;
               num_ff <= 73'(vnum < 0 ? -vnum : vnum);
               cnt_ff <= 7'd0;
               state_ff <= S_VDIVX;
            end
            S_EMIT: begin
               if (out_free) begin
                  emit_now = 1'b1;
                  oerr_ff <= ERR_NONE;
                  olast_ff <= 1'b0;
                  ovn_ff <= seg_ff;
                  if (seg_ff == 0) begin
                     orx_ff <= PointW'(cx_ff) + ox2_ff;
                     ory_ff <= PointW'(cy_ff) + oy2_ff;
                     olx_ff <= PointW'(cx_ff) - ox2_ff;
                     oly_ff <= PointW'(cy_ff) - oy2_ff;
                  end else begin
                     orx_ff <= PointW'(cx_ff) + PointW'(vx_ff);
                     ory_ff <= PointW'(cy_ff) + PointW'(vy_ff);
                     olx_ff <= PointW'(cx_ff) - PointW'(vx_ff);
                     oly_ff <= PointW'(cy_ff) - PointW'(vy_ff);
                  end
                  cx_ff <= ncx; cy_ff <= ncy;
                  psx_ff <= sx; psy_ff <= sy;
                  pox_ff <= ox2_ff; poy_ff <= oy2_ff;
                  seg_ff <= seg_ff + 11'd1;
                  state_ff <= final_pair ? S_EMIT2 : S_IDLE;
               end
            end
            S_EMIT2: begin
               if (out_free) begin
                  emit_now = 1'b1;
                  oerr_ff <= ERR_NONE;
                  olast_ff <= 1'b1;
                  ovn_ff <= seg_ff;
                  orx_ff <= PointW'(cx_ff) + ox2_ff;
                  ory_ff <= PointW'(cy_ff) + oy2_ff;
                  olx_ff <= PointW'(cx_ff) - ox2_ff;
                  oly_ff <= PointW'(cy_ff) - oy2_ff;
                  hw_ff <= '0;
                  seg_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // hold a waiting result, drop it once taken, load a new one
         ov_ff <= emit_now || (ov_ff && !rsp_ready);
      end
   end

endmodule

FILE: src/wire_outline_miter.sv
// Top level of the wire outline miter block.
// Each item enters a two-entry queue and is then handled by one sequencer that
// owns a shared square-root unit (two bits a cycle) and a restoring divider
// (one bit a cycle). A later segment, unlike the first, also needs the previous
// direction and two miter divisions. Results leave through an output register,
// so the sequencer computes on while one result waits, but holds in its check
// and emit states until that result is taken.
module wire_outline_miter
   import wom_pkg::*;
#(
   parameter int MAX_VERTICES = 1024
)
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_operation,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_wire_width,
   input  logic req_final_segment,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [41:0] rsp_right_x,
   output logic signed [41:0] rsp_right_y,
   output logic signed [41:0] rsp_left_x,
   output logic signed [41:0] rsp_left_y,
   output logic [10:0] rsp_vertex_number,
   output logic [2:0] rsp_error_code,
   output logic rsp_last_pair
);

   item_type in_item, q_item;
   logic q_valid, q_ready;

   assign in_item = '{op: req_operation, coord_x: req_coord_x, coord_y: req_coord_y,
                      wire_width: req_wire_width, final_segment: req_final_segment};

   wom_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   wom_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
      .clock(clock), .reset(reset),
      .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_right_x(rsp_right_x), .rsp_right_y(rsp_right_y),
      .rsp_left_x(rsp_left_x), .rsp_left_y(rsp_left_y),
      .rsp_vertex_number(rsp_vertex_number), .rsp_error_code(rsp_error_code),
      .rsp_last_pair(rsp_last_pair)
   );

endmodule

FILE: src/wom_checker.sv
// Port checker of the wire outline miter block, bound to the top level.
module wom_checker
   import wom_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [41:0] rsp_right_x,
   input logic [2:0] rsp_error_code,
   input logic rsp_last_pair
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_right_x))
      else $error("result dropped while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> rsp_right_x == '0 && !rsp_last_pair)
      else $error("error result carries outline data");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= ERR_PARALLEL)
      else $error("unknown error code");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule

bind wire_outline_miter wom_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_right_x(rsp_right_x), .rsp_error_code(rsp_error_code),
   .rsp_last_pair(rsp_last_pair)
);

FILE: tb/wire_outline_checker.sv
// Transfer monitor, outline predictor and result comparator for wire_outline_miter.
module wire_outline_checker
   import wom_pkg::*;
#(
   parameter int MAX_VERTICES = 1024
)
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic req_operation,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_wire_width,
   input  logic req_final_segment,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic signed [41:0] rsp_right_x,
   input  logic signed [41:0] rsp_right_y,
   input  logic signed [41:0] rsp_left_x,
   input  logic signed [41:0] rsp_left_y,
   input  logic [10:0] rsp_vertex_number,
   input  logic [2:0] rsp_error_code,
   input  logic rsp_last_pair,
   output int mismatches,
   output int outline_pending
);

   typedef struct {
      logic [41:0] right_x;
      logic [41:0] right_y;
      logic [41:0] left_x;
      logic [41:0] left_y;
      logic [10:0] vertex;
      logic [2:0] err;
      logic last;
   } outline_pair_type;

   outline_pair_type outline_q[$];

   longint wire_w, cx, cy, step_x, step_y, offs_x, offs_y;
   int unsigned seg_count;

   initial begin
      mismatches = 0;
      outline_pending = 0;
   end

   function automatic longint wrap40(longint v);
      logic signed [39:0] t;
      t = v[39:0];
      return t;
   endfunction

   function automatic longint unsigned root64(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   task automatic unit_direction(input longint dx, input longint dy,
                                 output longint ux, output longint uy);
      longint unsigned ax, ay, len, qx, qy;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax == 0 && ay == 0) begin
         ux = 0;
         uy = 0;
         return;
      end
      // normalize so the larger magnitude sits in [2^30, 2^31]
      while ((ax > ay ? ax : ay) < 64'd1 << 30) begin
         ax <<= 1;
         ay <<= 1;
      end
      len = root64(ax * ax + ay * ay);
      qx = (ax * 256 + len / 2) / len;
      qy = (ay * 256 + len / 2) / len;
      ux = dx < 0 ? -longint'(qx) : longint'(qx);
      uy = dy < 0 ? -longint'(qy) : longint'(qy);
   endtask

   task automatic push_pair(longint rx, longint ry, longint lx, longint ly,
                            int unsigned vn, logic [2:0] err, logic last);
      outline_pair_type p;
      p.right_x = rx[41:0];
      p.right_y = ry[41:0];
      p.left_x = lx[41:0];
      p.left_y = ly[41:0];
      p.vertex = vn[10:0];
      p.err = err;
      p.last = last;
      outline_q.push_back(p);
   endtask

   task automatic predict_outline(logic op, longint x, longint y, longint w, logic fin);
      int unsigned k;
      longint ux2, uy2, ox2, oy2, ux1, uy1, den, vx, vy;
      k = seg_count;
      if (op == OP_START) begin
         cx = wrap40(x * 256);
         cy = wrap40(y * 256);
         seg_count = 0;
         step_x = 0;
         step_y = 0;
         offs_x = 0;
         offs_y = 0;
         if (w <= 0) begin
            wire_w = 0;
            push_pair(0, 0, 0, 0, 0, ERR_WIDTH, 1'b0);
         end else begin
            wire_w = w;
         end
         return;
      end
      if (wire_w == 0) begin
         push_pair(0, 0, 0, 0, k, ERR_WIDTH, 1'b0);
         return;
      end
      if (x == 0 && y == 0) begin
         push_pair(0, 0, 0, 0, k, ERR_ZERO, 1'b0);
         return;
      end
      if (k > 0) begin
         if (step_x * x < -(step_y * y)) begin
            push_pair(0, 0, 0, 0, k, ERR_SHARP, 1'b0);
            return;
         end
         if (x * step_y == step_x * y) begin
            push_pair(0, 0, 0, 0, k, ERR_PARALLEL, 1'b0);
            return;
         end
      end
      unit_direction(x, y, ux2, uy2);
      ox2 = (wire_w * uy2) / 2;
      oy2 = -((wire_w * ux2) / 2);
      if (k == 0) begin
         push_pair(cx + ox2, cy + oy2, cx - ox2, cy - oy2, 0, ERR_NONE, 1'b0);
      end else begin
         unit_direction(step_x, step_y, ux1, uy1);
         den = 65536 + ux1 * ux2 + uy1 * uy2;
         if (den < 1) den = 1;
         vx = ((offs_x + ox2) * 65536) / den;
         vy = ((offs_y + oy2) * 65536) / den;
         push_pair(cx + vx, cy + vy, cx - vx, cy - vy, k, ERR_NONE, 1'b0);
      end
      cx = wrap40(cx + x * 256);
      cy = wrap40(cy + y * 256);
      step_x = x;
      step_y = y;
      offs_x = ox2;
      offs_y = oy2;
      seg_count = k + 1;
      if (fin || k + 1 >= MAX_VERTICES) begin
         push_pair(cx + ox2, cy + oy2, cx - ox2, cy - oy2, k + 1, ERR_NONE, 1'b1);
         wire_w = 0;
         seg_count = 0;
      end
   endtask

   task automatic report(string what, logic [41:0] got, logic [41:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      outline_pair_type e;
      if (reset) begin
         wire_w = 0;
         cx = 0;
         cy = 0;
         step_x = 0;
         step_y = 0;
         offs_x = 0;
         offs_y = 0;
         seg_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outline_q.size() == 0) begin
               report("unexpected result vertex", rsp_vertex_number, 0);
            end else begin
               e = outline_q.pop_front();
               if (rsp_right_x !== e.right_x) report("right_x", rsp_right_x, e.right_x);
               if (rsp_right_y !== e.right_y) report("right_y", rsp_right_y, e.right_y);
               if (rsp_left_x !== e.left_x) report("left_x", rsp_left_x, e.left_x);
               if (rsp_left_y !== e.left_y) report("left_y", rsp_left_y, e.left_y);
               if (rsp_vertex_number !== e.vertex)
                  report("vertex_number", rsp_vertex_number, e.vertex);
               if (rsp_error_code !== e.err) report("error_code", rsp_error_code, e.err);
               if (rsp_last_pair !== e.last) report("last_pair", rsp_last_pair, e.last);
            end
         end
         if (req_valid && req_ready)
            predict_outline(req_operation, req_coord_x, req_coord_y, req_wire_width,
                            req_final_segment);
      end
      outline_pending = outline_q.size();
   end

endmodule

FILE: tb/tb_wire_outline_miter.sv
// Stimulus, flow control and verdict for the wire_outline_miter testbench.
module tb_wire_outline_miter;
   import wom_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam int HoldOffCycles = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = OP_START;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic signed [31:0] req_wire_width = '0;
   logic req_final_segment = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [41:0] rsp_right_x, rsp_right_y, rsp_left_x, rsp_left_y;
   logic [10:0] rsp_vertex_number;
   logic [2:0] rsp_error_code;
   logic rsp_last_pair;

   int mismatches, outline_pending;
   int idle_cycles = 0;
   int results_seen = 0;
   bit burst_mode = 1'b0;
   longint last_x, last_y;

   always #1 clock = ~clock;

   wire_outline_miter u_top (.*);

   wire_outline_checker u_checker (.*);

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("timeout: no transfer for %0d cycles", WatchdogLimit);
         $display("** wire_outline_miter: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stalls, plus one long hold-off to back the block up
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 8);
         if (results_seen == 40) stall = HoldOffCycles;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_seen++;
         @(negedge clock);
      end
   end

   task automatic send_item(logic op, longint x, longint y, longint w, logic fin);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation <= op;
      req_coord_x <= x[31:0];
      req_coord_y <= y[31:0];
      req_wire_width <= w[31:0];
      req_final_segment <= fin;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic longint pick_coord();
      case ($urandom_range(0, 3))
         0: return longint'($urandom_range(0, 32)) - 16;
         1: return longint'($urandom_range(0, 2000)) - 1000;
         2: return longint'($urandom_range(0, 200000)) - 100000;
         default: return longint'($signed($urandom()));
      endcase
   endfunction

   // random increment that mostly keeps the turn at or under 90 degrees
   task automatic send_segment(logic fin, bit wild);
      longint x, y;
      x = pick_coord();
      y = pick_coord();
      if (!wild && last_x * x + last_y * y < 0 && x != -(64'sd1 << 31)
          && y != -(64'sd1 << 31)) begin
         x = -x;
         y = -y;
      end
      send_item(OP_SEGMENT, x, y, longint'($signed($urandom())), fin);
      last_x = x;
      last_y = y;
   endtask

   initial begin
      int sent, segs;
      longint w, a, b;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: width errors, open-wire checks, extremes, every error kind
      send_item(OP_START, 5, 5, -1, 1'b0);
      send_item(OP_START, 5, 5, 0, 1'b0);
      send_item(OP_SEGMENT, 3, 4, 9, 1'b0);
      send_item(OP_START, 32'sh7fffffff, -(64'sd1 << 31), 32'sh7fffffff, 1'b0);
      send_item(OP_SEGMENT, 0, 0, 0, 1'b1);
      send_item(OP_SEGMENT, -(64'sd1 << 31), 32'sh7fffffff, 0, 1'b0);
      send_item(OP_SEGMENT, 32'sh7fffffff, -(64'sd1 << 31), 0, 1'b0);
      send_item(OP_SEGMENT, -(64'sd1 << 31), 32'sh7fffffff, 0, 1'b1);
      send_item(OP_SEGMENT, -5, 100, 0, 1'b0);
      send_item(OP_SEGMENT, 1, 100, 0, 1'b1);
      send_item(OP_SEGMENT, 1, 1, 0, 1'b0);
      send_item(OP_START, 10, -10, 1, 1'b0);
      send_item(OP_SEGMENT, 1, 0, -1, 1'b1);
      send_item(OP_START, -(64'sd1 << 31), -(64'sd1 << 31), 32'sh7fffffff, 1'b0);
      send_item(OP_SEGMENT, -1, -1, 0, 1'b1);
      send_item(OP_START, 0, 0, 7, 1'b0);
      send_item(OP_SEGMENT, 5, 0, 0, 1'b0);
      send_item(OP_SEGMENT, 0, 5, 0, 1'b0);
      send_item(OP_SEGMENT, 5, 0, 0, 1'b1);
      sent = 19;

      // random wires; one very long wire runs into the vertex limit
      while (sent < 1550) begin
         if (sent % 64 < 8) burst_mode = 1'b1;
         else burst_mode = 1'b0;
         if (sent > 300 && sent < 400) begin
            send_item(OP_START, pick_coord(), pick_coord(),
                      longint'($urandom_range(1, 5000)), 1'b0);
            for (int i = 0; i < 1024; i++) begin
               a = longint'($urandom_range(1, 50));
               b = (i % 2) ? longint'($urandom_range(1, 50)) : 0;
               send_item(OP_SEGMENT, a, b, 0, 1'b0);
            end
            sent += 1025;
            continue;
         end
         if ($urandom_range(0, 9) == 0) begin
            // noise: unconstrained item
            send_item(1'($urandom_range(0, 1)), longint'($signed($urandom())),
                      longint'($signed($urandom())), longint'($signed($urandom())),
                      1'($urandom_range(0, 1)));
            sent++;
            continue;
         end
         case ($urandom_range(0, 5))
            0: w = longint'($signed($urandom()));
            1: w = longint'($urandom_range(1, 3));
            default: w = longint'($urandom_range(1, 100000));
         endcase
         send_item(OP_START, pick_coord(), pick_coord(), w, 1'($urandom_range(0, 1)));
         last_x = 0;
         last_y = 0;
         segs = $urandom_range(1, 8);
         for (int i = 0; i < segs; i++)
            send_segment(i == segs - 1 && $urandom_range(0, 7) != 0, $urandom_range(0, 15) == 0);
         sent += segs + 1;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      burst_mode = 1'b0;
      while (outline_pending != 0) @(negedge clock);
      repeat (1000) @(negedge clock);
      if (mismatches == 0 && outline_pending == 0) begin
         $display("** wire_outline_miter: PASSED **");
      end else begin
         $display("** wire_outline_miter: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/wom_pkg.sv
src/wom_queue.sv
src/wom_engine.sv
src/wire_outline_miter.sv
src/wom_checker.sv
tb/wire_outline_checker.sv
tb/tb_wire_outline_miter.sv
